@@ design/mrfp_pkg.sv @@
// Shared types and constants for the meter reply frame parser.
// No dependencies; used by every module of the block.
package mrfp_pkg;

	localparam int BYTE_W  = 8;
	localparam int POS_W   = 4;
	localparam int SUM_W   = 16;
	localparam int NPAY    = 6;
	localparam int PIDX_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int TDATA_W = 64;

	// Frame positions
	localparam logic [POS_W-1:0] POS_HDR1    = 4'd0;
	localparam logic [POS_W-1:0] POS_HDR2    = 4'd1;
	localparam logic [POS_W-1:0] POS_LEN     = 4'd2;
	localparam logic [POS_W-1:0] POS_CODE    = 4'd3;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 4'd4;

	// Legal frame lengths
	localparam logic [BYTE_W-1:0] LEN_ACK  = 8'h02;
	localparam logic [BYTE_W-1:0] LEN_DATA = 8'h04;
	localparam logic [BYTE_W-1:0] LEN_INFO = 8'h08;

	// Configuration register indexes
	localparam logic [CIDX_W-1:0] REG_HDR1      = 3'd0;
	localparam logic [CIDX_W-1:0] REG_HDR2      = 3'd1;
	localparam logic [CIDX_W-1:0] REG_ACK_CODE  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_DATA_CODE = 3'd3;
	localparam logic [CIDX_W-1:0] REG_INFO_CODE = 3'd4;

	// Register reset values
	localparam logic [BYTE_W-1:0] RST_HDR1      = 8'hAA;
	localparam logic [BYTE_W-1:0] RST_HDR2      = 8'h55;
	localparam logic [BYTE_W-1:0] RST_ACK_CODE  = 8'hF0;
	localparam logic [BYTE_W-1:0] RST_DATA_CODE = 8'hF6;
	localparam logic [BYTE_W-1:0] RST_INFO_CODE = 8'hF5;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_INFO  = 2'd2,
		KIND_ERROR = 2'd3
	} reply_kind_t;

	typedef struct packed {
		logic [31:0] meter_id;
		logic [7:0]  meter_class;
		logic [7:0]  meter_range;
		logic [15:0] measured_value;
		reply_kind_t reply_kind;
	} result_t;

	typedef struct packed {
		logic              step;
		logic [BYTE_W-1:0] rx_byte;
	} step_t;

	typedef struct packed {
		logic    valid;
		result_t res;
	} result_out_t;

endpackage

@@ design/meter_reply_frame_parser_core.sv @@
// Meter reply frame parser, top level.
// The closing byte's result passes the input stage and result registers to m_tvalid.
// Throughput: one byte per cycle; the single parse step between the input stage register
// and the result register sets that figure. The input stage only holds while a result waits.
// Reset (arst_n low, asynchronous): parser hunts the first header byte, registers take
// their default values, both stream sides empty.
module meter_reply_frame_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// receive stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] measured_value, [23:16] meter_range,
	                               // [31:24] meter_class, [63:32] meter_id
	output logic [1:0]  m_tuser,   // [1:0] reply_kind
	// register writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic                        valid_s1;
	logic [mrfp_pkg::BYTE_W-1:0] byte_s1;
	logic                        take;
	mrfp_pkg::step_t             step;
	mrfp_pkg::result_out_t       result;

	// Parse the staged byte whenever the result slot is free or being drained this cycle.
	assign take         = valid_s1 && (!m_tvalid || m_tready);
	assign step.step    = take;
	assign step.rx_byte = byte_s1;

	mrfp_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// Header hunt, length check, running sum and result decode.
	mrfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_in   (step),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	mrfp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.result   (result),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ design/mrfp_in_reg.sv @@
// Input stage register for the meter reply frame parser.
// Depends on mrfp_pkg.
module mrfp_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
	input  logic                       take,
	output logic                       valid_s1,
	output logic [mrfp_pkg::BYTE_W-1:0] byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

@@ design/mrfp_parser.sv @@
// Frame state, configuration registers and per-byte parse logic.
// Depends on mrfp_pkg.
module mrfp_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mrfp_pkg::step_t             step_in,
	input  logic                        cfg_we,
	input  logic [mrfp_pkg::CIDX_W-1:0] cfg_index,
	input  logic [mrfp_pkg::BYTE_W-1:0] cfg_data,
	output mrfp_pkg::result_out_t       result
);

	logic [mrfp_pkg::BYTE_W-1:0] hdr1_q, hdr2_q, ack_code_q, data_code_q, info_code_q;
	logic [mrfp_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [mrfp_pkg::BYTE_W-1:0] len_q, len_d, code_q, code_d, chk_hi_q, chk_hi_d;
	logic [mrfp_pkg::SUM_W-1:0]  sum_q, sum_d;
	logic [mrfp_pkg::BYTE_W-1:0] payload_q [mrfp_pkg::NPAY];
	logic                        pay_we;
	logic [mrfp_pkg::PIDX_W-1:0] pay_idx;
	logic [mrfp_pkg::BYTE_W-1:0] b;
	logic [mrfp_pkg::BYTE_W-1:0] pos8, pay_end;
	logic [mrfp_pkg::POS_W-1:0]  pos_off;
	logic [mrfp_pkg::SUM_W-1:0]  sum_add;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q      <= mrfp_pkg::RST_HDR1;
			hdr2_q      <= mrfp_pkg::RST_HDR2;
			ack_code_q  <= mrfp_pkg::RST_ACK_CODE;
			data_code_q <= mrfp_pkg::RST_DATA_CODE;
			info_code_q <= mrfp_pkg::RST_INFO_CODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mrfp_pkg::REG_HDR1:      hdr1_q      <= cfg_data;
				mrfp_pkg::REG_HDR2:      hdr2_q      <= cfg_data;
				mrfp_pkg::REG_ACK_CODE:  ack_code_q  <= cfg_data;
				mrfp_pkg::REG_DATA_CODE: data_code_q <= cfg_data;
				mrfp_pkg::REG_INFO_CODE: info_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign b       = step_in.rx_byte;
	assign pos8    = {{(mrfp_pkg::BYTE_W-mrfp_pkg::POS_W){1'b0}}, pos_q};
	// first checksum byte sits at 4 + (len - 2)
	assign pay_end = len_q + 8'd2;
	assign pos_off = pos_q - mrfp_pkg::POS_PAYLOAD;
	assign sum_add = sum_q + {8'd0, b};

	always_comb begin
		pos_d   = pos_q;
		len_d   = len_q;
		code_d  = code_q;
		sum_d   = sum_q;
		chk_hi_d = chk_hi_q;
		pay_we  = 1'b0;
		pay_idx = pos_off[mrfp_pkg::PIDX_W-1:0];
		result.valid = 1'b0;
		result.res   = '0;
		result.res.reply_kind = mrfp_pkg::KIND_ERROR;

		if (pos_q == mrfp_pkg::POS_HDR1) begin
			if (b == hdr1_q) pos_d = mrfp_pkg::POS_HDR2;
		end else if (pos_q == mrfp_pkg::POS_HDR2) begin
			if (b == hdr2_q)      pos_d = mrfp_pkg::POS_LEN;
			else if (b != hdr1_q) pos_d = mrfp_pkg::POS_HDR1;
		end else if (pos_q == mrfp_pkg::POS_LEN) begin
			if (b != mrfp_pkg::LEN_ACK && b != mrfp_pkg::LEN_DATA && b != mrfp_pkg::LEN_INFO) begin
				result.valid = 1'b1;
				pos_d  = mrfp_pkg::POS_HDR1;
				len_d  = '0;
				code_d = '0;
				sum_d  = '0;
				chk_hi_d = '0;
			end else begin
				len_d = b;
				sum_d = {8'd0, b};
				pos_d = mrfp_pkg::POS_CODE;
			end
		end else if (pos_q == mrfp_pkg::POS_CODE) begin
			code_d = b;
			sum_d  = sum_add;
			pos_d  = mrfp_pkg::POS_PAYLOAD;
		end else if (pos8 < pay_end) begin
			pay_we = 1'b1;
			sum_d  = sum_add;
			pos_d  = pos_q + 4'd1;
		end else if (pos8 == pay_end) begin
			chk_hi_d = b;
			pos_d    = pos_q + 4'd1;
		end else begin
			// checksum low byte closes the frame
			result.valid = 1'b1;
			if ({chk_hi_q, b} == sum_q) begin
				if (len_q == mrfp_pkg::LEN_ACK && code_q == ack_code_q) begin
					result.res.reply_kind = mrfp_pkg::KIND_ACK;
				end else if (len_q == mrfp_pkg::LEN_DATA && code_q == data_code_q) begin
					result.res.reply_kind     = mrfp_pkg::KIND_DATA;
					result.res.measured_value = {payload_q[1], payload_q[0]};
				end else if (len_q == mrfp_pkg::LEN_INFO && code_q == info_code_q) begin
					result.res.reply_kind  = mrfp_pkg::KIND_INFO;
					result.res.meter_range = payload_q[0];
					result.res.meter_class = payload_q[1];
					result.res.meter_id    = {payload_q[5], payload_q[4],
					                          payload_q[3], payload_q[2]};
				end
			end
			pos_d  = mrfp_pkg::POS_HDR1;
			len_d  = '0;
			code_d = '0;
			sum_d  = '0;
			chk_hi_d = '0;
		end

		if (!step_in.step) begin
			result.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= mrfp_pkg::POS_HDR1;
			len_q    <= '0;
			code_q   <= '0;
			sum_q    <= '0;
			chk_hi_q <= '0;
		end else if (step_in.step) begin
			pos_q    <= pos_d;
			len_q    <= len_d;
			code_q   <= code_d;
			sum_q    <= sum_d;
			chk_hi_q <= chk_hi_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_in.step && pay_we) begin
			payload_q[pay_idx] <= b;
		end
	end

endmodule

@@ design/mrfp_out_reg.sv @@
// Result register driving the master-side stream of the parser.
// Depends on mrfp_pkg.
module mrfp_out_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mrfp_pkg::result_out_t        result,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [mrfp_pkg::TDATA_W-1:0] m_tdata,  // [15:0] measured_value, [23:16] meter_range,
	                                               // [31:24] meter_class, [63:32] meter_id
	output logic [1:0]                   m_tuser   // [1:0] reply_kind
);

	mrfp_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (result.valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			res_q <= result.res;
		end
	end

	assign m_tdata = {res_q.meter_id, res_q.meter_class, res_q.meter_range, res_q.measured_value};
	assign m_tuser = res_q.reply_kind;

endmodule
